/* sv/sample_bit_packer_macros.svh */
// assertion macros used by the sample bit packer checker
`ifndef SAMPLE_BIT_PACKER_MACROS_SVH
`define SAMPLE_BIT_PACKER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define SBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// checks what must hold in the cycle after reset
`define SBP_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sbp_pkg.sv */
// shared constants, types and helpers for the sample bit packer
`default_nettype none

package sbp_pkg;

    localparam int WORD_BITS    = 16;
    localparam int SAMPLE_FULL  = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int DATA_W       = 16;
    localparam int WIDTH_W      = 5;
    localparam int ACC_BITS     = 3 * WORD_BITS;
    localparam int CNT_W        = $clog2(ACC_BITS + 1);
    localparam int K_W          = $clog2(RESULT_LIMIT);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_BITS = 2'd0,
        CFG_UNPACK_MODE = 2'd1,
        CFG_STEREO      = 2'd2
    } t_cfg_idx;

    // pending bitstream, valid bits right-aligned
    typedef struct packed {
        logic [ACC_BITS-1:0] acc;
        logic [CNT_W-1:0]    n;
        logic [K_W-1:0]      k;
    } t_stream;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last_out;
        logic              done;
        t_stream           post;
    } t_slice;

    // out-of-range widths clamp to 1..16
    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] bits);
        logic [WIDTH_W-1:0] w;
        if (bits == '0) begin
            w = WIDTH_W'(1);
        end else if (bits > WIDTH_W'(SAMPLE_FULL)) begin
            w = WIDTH_W'(SAMPLE_FULL);
        end else begin
            w = bits;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

/* sv/sbp_if.sv */
// request channel interfaces for the sample bit packer
`default_nettype none

interface sbp_in_if;
    logic                       valid;
    logic                       ready;
    logic [sbp_pkg::DATA_W-1:0] word_a;
    logic [sbp_pkg::DATA_W-1:0] word_b;
    logic                       last;

    modport source (output valid, output word_a, output word_b, output last, input ready);
    modport sink   (input valid, input word_a, input word_b, input last, output ready);
endinterface

interface sbp_out_if;
    logic                       valid;
    logic                       ready;
    logic [sbp_pkg::DATA_W-1:0] data;
    logic                       last_out;

    modport source (output valid, output data, output last_out, input ready);
    modport sink   (input valid, input data, input last_out, output ready);
endinterface

`default_nettype wire

/* sv/sbp_slicer.sv */
// cuts one result off the front of the pending bitstream
`default_nettype none

module sbp_slicer (
    input  wire sbp_pkg::t_stream               i_state,
    input  wire                                 i_last,
    input  wire                                 i_unpack,
    input  wire logic [sbp_pkg::WIDTH_W-1:0]    i_w,
    output sbp_pkg::t_slice                     o_res
);

    logic [sbp_pkg::CNT_W-1:0]  sh;
    logic [sbp_pkg::CNT_W-1:0]  w6;
    logic [sbp_pkg::DATA_W-1:0] smp;

    always_comb begin
        w6           = sbp_pkg::CNT_W'(i_w);
        sh           = '0;
        smp          = '0;
        o_res.data   = '0;
        o_res.post   = i_state;
        o_res.done   = 1'b1;
        if (!i_unpack) begin
            if (i_state.n >= sbp_pkg::CNT_W'(sbp_pkg::WORD_BITS)) begin
                sh           = i_state.n - sbp_pkg::CNT_W'(sbp_pkg::WORD_BITS);
                o_res.data   = sbp_pkg::DATA_W'(i_state.acc >> sh);
                o_res.post.n = sh;
            end else begin
                // flush of a partial word, zero padded at the bottom
                o_res.data   = i_state.acc[sbp_pkg::DATA_W-1:0]
                               << (sbp_pkg::CNT_W'(sbp_pkg::WORD_BITS) - i_state.n);
                o_res.post.n = '0;
            end
            o_res.done = !((o_res.post.n >= sbp_pkg::CNT_W'(sbp_pkg::WORD_BITS)) ||
                           (i_last && (o_res.post.n != '0)));
        end else begin
            sh           = i_state.n - w6;
            smp          = sbp_pkg::DATA_W'(i_state.acc >> sh)
                           & ~({sbp_pkg::DATA_W{1'b1}} << i_w);
            o_res.data   = smp << (sbp_pkg::CNT_W'(sbp_pkg::SAMPLE_FULL) - w6);
            o_res.post.n = sh;
            o_res.post.k = i_state.k + sbp_pkg::K_W'(1);
            o_res.done   = (sh < w6) ||
                           (i_state.k == sbp_pkg::K_W'(sbp_pkg::RESULT_LIMIT - 1));
        end
        o_res.last_out = o_res.done && i_last;
        // end of stream leaves nothing pending
        if (o_res.done && i_last) begin
            o_res.post.n = '0;
        end
    end

endmodule

`default_nettype wire

/* sv/sample_bit_packer.sv */
// top level of the variable-width sample bit packer
//
//  channel   dir   fields                          handshake
//  i_in      in    word_a, word_b, last            valid/ready
//  o_out     out   data, last_out                  valid/ready
//  i_cfg_*   in    idx, data (sample_bits, mode, stereo) write enable only
//
// one request in per cycle while ready; a request leaves its results one per cycle
// through the output register while it is not stalled: pack yields 0..3 words,
// unpack yields min(16, (n+16)/w) samples
// the next request merges into the stream in the cycle its last result is cut
// reset is synchronous; no clearing pass
// a stalled output holds the slicer; while busy, input ready stays low until it moves
`default_nettype none

module sample_bit_packer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire logic [sbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbp_in_if.sink                              i_in,
    sbp_out_if.source                           o_out
);

    logic [sbp_pkg::WIDTH_W-1:0] r_sample_bits, n_sample_bits;
    logic                        r_unpack, n_unpack;
    logic                        r_stereo, n_stereo;
    sbp_pkg::t_stream            r_stream, n_stream;
    logic                        r_busy, n_busy;
    logic                        r_last, n_last;
    logic                        r_ovalid, n_ovalid;
    logic [sbp_pkg::DATA_W-1:0]  r_odata;
    logic                        r_olast;

    logic [sbp_pkg::WIDTH_W-1:0] w;
    sbp_pkg::t_slice             slice;
    sbp_pkg::t_stream            base;
    sbp_pkg::t_stream            merged;
    logic                        m_busy;
    logic [sbp_pkg::DATA_W-1:0]  sa;
    logic [sbp_pkg::DATA_W-1:0]  sb;
    logic                        slot_free;
    logic                        emit_fire;
    logic                        final_emit;
    logic                        accept;

    assign w = sbp_pkg::eff_width(r_sample_bits);

    sbp_slicer u_slicer (
        .i_state  (r_stream),
        .i_last   (r_last),
        .i_unpack (r_unpack),
        .i_w      (w),
        .o_res    (slice)
    );

    assign slot_free  = !r_ovalid || o_out.ready;
    assign emit_fire  = r_busy && slot_free;
    assign final_emit = emit_fire && slice.done;
    assign i_in.ready = !r_busy || final_emit;
    assign accept     = i_in.valid && i_in.ready;

    // append the new request to what the previous one left behind
    always_comb begin
        base = r_busy ? slice.post : r_stream;
        sa   = i_in.word_a >> (sbp_pkg::WIDTH_W'(sbp_pkg::SAMPLE_FULL) - w);
        sb   = i_in.word_b >> (sbp_pkg::WIDTH_W'(sbp_pkg::SAMPLE_FULL) - w);
        merged   = base;
        merged.k = '0;
        if (r_unpack) begin
            merged.acc = (base.acc << sbp_pkg::DATA_W)
                         | sbp_pkg::ACC_BITS'(i_in.word_a);
            merged.n   = base.n + sbp_pkg::CNT_W'(sbp_pkg::DATA_W);
            m_busy     = 1'b1;
        end else begin
            if (r_stereo) begin
                merged.acc = (base.acc << {w, 1'b0})
                             | (sbp_pkg::ACC_BITS'(sa) << w)
                             | sbp_pkg::ACC_BITS'(sb);
                merged.n   = base.n + sbp_pkg::CNT_W'({w, 1'b0});
            end else begin
                merged.acc = (base.acc << w) | sbp_pkg::ACC_BITS'(sa);
                merged.n   = base.n + sbp_pkg::CNT_W'(w);
            end
            m_busy = (merged.n >= sbp_pkg::CNT_W'(sbp_pkg::WORD_BITS)) || i_in.last;
        end
    end

    always_comb begin
        n_sample_bits = r_sample_bits;
        n_unpack      = r_unpack;
        n_stereo      = r_stereo;
        n_stream      = r_stream;
        n_busy        = r_busy;
        n_last        = r_last;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                sbp_pkg::CFG_SAMPLE_BITS: n_sample_bits = i_cfg_data;
                sbp_pkg::CFG_UNPACK_MODE: n_unpack      = i_cfg_data[0];
                sbp_pkg::CFG_STEREO:      n_stereo      = i_cfg_data[0];
                default:                  ;
            endcase
            // any known register write starts a new stream
            if (i_cfg_idx == sbp_pkg::CFG_SAMPLE_BITS ||
                i_cfg_idx == sbp_pkg::CFG_UNPACK_MODE ||
                i_cfg_idx == sbp_pkg::CFG_STEREO) begin
                n_stream.n = '0;
                n_stream.k = '0;
                n_busy     = 1'b0;
            end
        end else if (accept) begin
            n_stream = merged;
            n_busy   = m_busy;
            n_last   = i_in.last;
        end else if (emit_fire) begin
            n_stream = slice.post;
            n_busy   = !slice.done;
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (emit_fire) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_bits <= sbp_pkg::WIDTH_W'(sbp_pkg::SAMPLE_FULL);
            r_unpack      <= 1'b0;
            r_stereo      <= 1'b0;
            r_stream      <= '0;
            r_busy        <= 1'b0;
            r_last        <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_sample_bits <= n_sample_bits;
            r_unpack      <= n_unpack;
            r_stereo      <= n_stereo;
            r_stream      <= n_stream;
            r_busy        <= n_busy;
            r_last        <= n_last;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_odata <= slice.data;
            r_olast <= slice.last_out;
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.data     = r_odata;
    assign o_out.last_out = r_olast;

endmodule

`default_nettype wire

/* sv/sbp_checker.sv */
// port-level assertions for the sample bit packer, bound to the top level
`default_nettype none

`include "sample_bit_packer_macros.svh"

module sbp_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_cfg_we,
    input wire logic [sbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input wire logic [sbp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input wire                                 i_in_ready,
    input wire                                 i_out_valid,
    input wire                                 i_out_ready,
    input wire logic [sbp_pkg::DATA_W-1:0]     i_out_data
);

    logic [sbp_pkg::WIDTH_W-1:0] r_bits;
    logic                        r_mode;
    logic [sbp_pkg::DATA_W-1:0]  c_zero_mask;

    // shadow of the width and mode registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= sbp_pkg::WIDTH_W'(sbp_pkg::SAMPLE_FULL);
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sbp_pkg::CFG_SAMPLE_BITS) begin
                r_bits <= i_cfg_data;
            end
            if (i_cfg_idx == sbp_pkg::CFG_UNPACK_MODE) begin
                r_mode <= i_cfg_data[0];
            end
        end
    end

    assign c_zero_mask = {sbp_pkg::DATA_W{1'b1}} >> sbp_pkg::eff_width(r_bits);

    `SBP_ASSERT_AFTER_RESET(a_idle_after_reset, i_clk, i_rst_n, !i_out_valid, "output valid right after reset")

    `SBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")

    `SBP_ASSERT_NOW(a_unpack_low_zero, i_clk, i_rst_n, i_out_valid && r_mode, (i_out_data & c_zero_mask) == '0, "unpacked sample has low bits set")

    `SBP_ASSERT_NEXT(a_busy_emits, i_clk, i_rst_n, !i_in_ready, i_out_valid, "input held off with no result pending")

endmodule

bind sample_bit_packer sbp_checker u_sbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
